FILE: src/iabd_pkg.sv
package iabd_pkg;

  localparam int unsigned MAX_INDEX = 88;
  localparam int unsigned IDX_W     = 7;

  // APB register map
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEREO_MODE = 1'b0;

  // header byte within one channel's four-byte group
  typedef enum logic [1:0] {
    HF_PRED_LO = 2'd0,
    HF_PRED_HI = 2'd1,
    HF_STEP    = 2'd2,
    HF_RSVD    = 2'd3
  } hdr_field_t;

  function automatic logic [14:0] step_lookup(input logic [IDX_W-1:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;  // index 88 and above
    endcase
    return s;
  endfunction

  // next step index: -1 for magnitudes 0..3, else +2/+4/+6/+8, clamped to 0..88
  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                  input logic [2:0] mag);
    logic [IDX_W:0] sum;
    logic [IDX_W-1:0] res;
    sum = {1'b0, idx} + {{(IDX_W-2){1'b0}}, mag[1:0], 1'b0} + {{IDX_W{1'b0}}, 1'b1}
          + {{IDX_W{1'b0}}, 1'b1};
    if (!mag[2]) begin
      res = (idx == '0) ? '0 : idx - 1'b1;
    end else if (sum > (IDX_W+1)'(MAX_INDEX)) begin
      res = IDX_W'(MAX_INDEX);
    end else begin
      res = sum[IDX_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: src/ima_adpcm_block_decoder.sv
// A data byte is held in the work stage, and its low-nibble sample and then its
//   high-nibble sample are loaded into the output register; header bytes give none.
// Throughput: a data byte holds the single decode slice for both samples; the next
//   byte enters as its high nibble decodes; header bytes one per cycle.
// Reset (synchronous, rst_n low): mono mode, predictors and step indexes zero,
//   header parse armed at byte zero, both pipeline registers empty.
module ima_adpcm_block_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] in_byte
  input  logic                               in_tuser,   // [0] chunk_start
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] sample
  output logic                               out_tuser,  // [0] channel
  output logic                               out_tlast,  // second sample of a byte
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [iabd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int unsigned IW = iabd_pkg::IDX_W;

  // configuration
  logic stereo_r;

  // header parser state
  logic       in_header_r, in_header_nxt;
  logic [2:0] pos_r, pos_nxt;

  // decoder state
  logic [15:0]   pred_r [2];
  logic [IW-1:0] idx_r  [2];

  // work stage
  logic                 wk_valid_r, wk_valid_nxt;
  logic                 wk_hdr_r;
  iabd_pkg::hdr_field_t wk_field_r;
  logic                 wk_ch_r;
  logic [7:0]           wk_byte_r;
  logic                 wk_phase_r, wk_phase_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_sample_r;
  logic        out_ch_r;
  logic        out_last_r;

  logic in_acc, out_free, advance, done, cfg_wr;
  logic hdr_eff;
  logic [2:0] pos_eff;
  logic [2:0] hdr_last;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite
                  && (cfg_paddr == iabd_pkg::REG_STEREO_MODE);
  assign cfg_prdata = (cfg_paddr == iabd_pkg::REG_STEREO_MODE) ? {31'd0, stereo_r} : 32'd0;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = wk_valid_r && (wk_hdr_r || out_free);
  assign done      = advance && (wk_hdr_r || wk_phase_r);
  assign in_tready = !wk_valid_r || done;
  assign in_acc    = in_tvalid && in_tready;

  // header / data classification at acceptance
  assign hdr_eff  = in_tuser || in_header_r;
  assign pos_eff  = in_tuser ? 3'd0 : pos_r;
  assign hdr_last = stereo_r ? 3'd7 : 3'd3;

  always_comb begin
    in_header_nxt = in_header_r;
    pos_nxt       = pos_r;
    if (in_acc) begin
      if (hdr_eff) begin
        if (pos_eff >= hdr_last) begin
          in_header_nxt = 1'b0;
          pos_nxt       = 3'd0;
        end else begin
          in_header_nxt = 1'b1;
          pos_nxt       = pos_eff + 3'd1;
        end
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  // nibble decode
  logic [3:0]    nib;
  logic [14:0]   step;
  logic [16:0]   diff;
  logic [17:0]   p_sum;
  logic [15:0]   p_sat;
  logic [IW-1:0] idx_new;

  assign nib  = wk_phase_r ? wk_byte_r[7:4] : wk_byte_r[3:0];
  assign step = iabd_pkg::step_lookup(idx_r[wk_ch_r]);

  always_comb begin
    diff = {5'd0, step[14:3]};
    if (nib[2]) diff = diff + {2'd0, step};
    if (nib[1]) diff = diff + {3'd0, step[14:1]};
    if (nib[0]) diff = diff + {4'd0, step[14:2]};
    if (nib[3]) begin
      p_sum = {{2{pred_r[wk_ch_r][15]}}, pred_r[wk_ch_r]} - {1'b0, diff};
    end else begin
      p_sum = {{2{pred_r[wk_ch_r][15]}}, pred_r[wk_ch_r]} + {1'b0, diff};
    end
    if (!p_sum[17] && (p_sum[16:15] != 2'b00)) begin
      p_sat = 16'h7fff;
    end else if (p_sum[17] && (p_sum[16:15] != 2'b11)) begin
      p_sat = 16'h8000;
    end else begin
      p_sat = p_sum[15:0];
    end
    idx_new = iabd_pkg::next_index(idx_r[wk_ch_r], nib[2:0]);
  end

  always_comb begin
    wk_valid_nxt  = wk_valid_r;
    wk_phase_nxt  = wk_phase_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (advance && !wk_hdr_r) out_valid_nxt = 1'b1;
    if (done) wk_valid_nxt = 1'b0;
    if (advance && !wk_hdr_r) wk_phase_nxt = !wk_phase_r;
    if (in_acc) begin
      wk_valid_nxt = 1'b1;
      wk_phase_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r    <= 1'b0;
      in_header_r <= 1'b1;
      pos_r       <= 3'd0;
      wk_valid_r  <= 1'b0;
      wk_phase_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pred_r[0]   <= 16'd0;
      pred_r[1]   <= 16'd0;
      idx_r[0]    <= '0;
      idx_r[1]    <= '0;
    end else begin
      if (cfg_wr) stereo_r <= cfg_pwdata[0];
      in_header_r <= in_header_nxt;
      pos_r       <= pos_nxt;
      wk_valid_r  <= wk_valid_nxt;
      wk_phase_r  <= wk_phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        if (wk_hdr_r) begin
          case (wk_field_r)
            iabd_pkg::HF_PRED_LO: pred_r[wk_ch_r][7:0]  <= wk_byte_r;
            iabd_pkg::HF_PRED_HI: pred_r[wk_ch_r][15:8] <= wk_byte_r;
            iabd_pkg::HF_STEP: begin
              idx_r[wk_ch_r] <= (wk_byte_r > 8'(iabd_pkg::MAX_INDEX))
                                ? IW'(iabd_pkg::MAX_INDEX) : wk_byte_r[IW-1:0];
            end
            default: ;
          endcase
        end else begin
          pred_r[wk_ch_r] <= p_sat;
          idx_r[wk_ch_r]  <= idx_new;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      wk_hdr_r   <= hdr_eff;
      wk_field_r <= iabd_pkg::hdr_field_t'(pos_eff[1:0]);
      wk_ch_r    <= hdr_eff ? pos_eff[2] : (stereo_r & pos_r[2]);
      wk_byte_r  <= in_tdata;
    end
    if (advance && !wk_hdr_r) begin
      out_sample_r <= p_sat;
      out_ch_r     <= wk_ch_r;
      out_last_r   <= wk_phase_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_ch_r;
  assign out_tlast  = out_last_r;

  // step indexes stay within the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r[0] <= IW'(iabd_pkg::MAX_INDEX)) && (idx_r[1] <= IW'(iabd_pkg::MAX_INDEX)))
    else $error("step index out of range");

  // low nibble decoded -> high nibble of the same byte is next
  a_low_then_high: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !wk_hdr_r && !wk_phase_r) |=> (wk_valid_r && wk_phase_r && !wk_hdr_r))
    else $error("high nibble lost after low nibble");

  // a new byte never overwrites a data byte whose high nibble is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !(wk_valid_r && !wk_hdr_r && !wk_phase_r))
    else $error("work stage overwritten");

  // output register only loaded when free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && wk_valid_r && !wk_hdr_r) |=> $stable(out_sample_r))
    else $error("pending sample overwritten");

endmodule

FILE: tb/tb_ima_adpcm_block_decoder.sv
`timescale 1ns / 1ps

module tb_ima_adpcm_block_decoder;

  localparam int TOTAL_ITEMS    = 700;
  localparam int CALM_FROM      = 620;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int STEP_SIZE [89] = '{
    7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41,
    45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190,
    209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658, 724,
    796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272,
    2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132,
    7845, 8630, 9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500,
    20350, 22385, 24623, 27086, 29794, 32767
  };
  localparam int IDX_SHIFT [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};

  typedef struct packed {
    logic signed [15:0] sample;
    logic               chan;
    logic               hi_nib;
  } pcm_t;

  typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [7:0]         val;
    logic               start;
    logic               fixed;
    logic signed [15:0] f_lo;
    logic signed [15:0] f_hi;
  } stim_row_t;

  // fixed rows carry samples that follow directly from saturation or from a zero step difference
  localparam stim_row_t DIRECTED [27] = '{
    // header and data with no block start after reset
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h80, 1'b0, 1'b1, 16'sh0000, 16'sh0000},
    '{ROW_MODE, 8'h01, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    // stereo: left at +max with step index clipped, right at -max
    '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h7F, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h59, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h5A, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h77, 1'b0, 1'b1, 16'sh7FFF, 16'sh7FFF},
    '{ROW_BYTE, 8'h3C, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h96, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'hE1, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 16'sh8000, 16'sh8000},
    // stereo header cut short by a switch to mono
    '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h02, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h03, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h04, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_MODE, 8'h00, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h06, 1'b0, 1'b0, 16'sh0000, 16'sh0000},
    '{ROW_BYTE, 8'h21, 1'b0, 1'b0, 16'sh0000, 16'sh0000}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        in_tuser;   // [0] chunk_start
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] sample
  logic        out_tuser;  // [0] channel
  logic        out_tlast;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [iabd_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]                     cfg_pwdata;
  logic [31:0]                     cfg_prdata;
  logic                            cfg_pready;

  // travels alongside each input transaction
  logic               fixed_vld;
  logic signed [15:0] fixed_lo;
  logic signed [15:0] fixed_hi;

  // decoder state as predicted
  bit                         mode_stereo;
  logic signed [15:0]         dec_pred [2];
  logic [iabd_pkg::IDX_W-1:0] dec_index [2];
  logic [2:0]                 byte_pos;
  bit                         parsing_hdr;
  pcm_t                       pcm_fifo [$];

  int n_errors;
  int n_sent;
  int quiet_cycles;
  bit calm;
  bit gaps_on;
  bit stalls_on;

  ima_adpcm_block_decoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pcm_t decode_nib(bit ch, logic [3:0] nib, bit hi);
    int   step;
    int   diff;
    int   acc;
    int   nidx;
    pcm_t r;
    step = STEP_SIZE[dec_index[ch]];
    diff = step >>> 3;
    if (nib[2]) diff += step;
    if (nib[1]) diff += step >>> 1;
    if (nib[0]) diff += step >>> 2;
    acc = int'(dec_pred[ch]);
    acc = nib[3] ? acc - diff : acc + diff;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    dec_pred[ch] = 16'(acc);
    nidx = int'(dec_index[ch]) + IDX_SHIFT[nib[2:0]];
    if (nidx < 0) nidx = 0;
    if (nidx > int'(iabd_pkg::MAX_INDEX)) nidx = int'(iabd_pkg::MAX_INDEX);
    dec_index[ch] = iabd_pkg::IDX_W'(nidx);
    r.sample = dec_pred[ch];
    r.chan   = ch;
    r.hi_nib = hi;
    return r;
  endfunction

  function automatic void take_byte(logic [7:0] b, logic start, logic fixed,
                                    logic signed [15:0] f_lo, logic signed [15:0] f_hi);
    bit   ch;
    pcm_t r;
    if (start) begin
      parsing_hdr = 1'b1;
      byte_pos    = '0;
    end
    if (parsing_hdr) begin
      ch = byte_pos[2];
      case (iabd_pkg::hdr_field_t'(byte_pos[1:0]))
        iabd_pkg::HF_PRED_LO: dec_pred[ch][7:0]  = b;
        iabd_pkg::HF_PRED_HI: dec_pred[ch][15:8] = b;
        iabd_pkg::HF_STEP: begin
          dec_index[ch] = (b > iabd_pkg::MAX_INDEX) ? iabd_pkg::IDX_W'(iabd_pkg::MAX_INDEX)
                                                    : iabd_pkg::IDX_W'(b);
        end
        default: ;
      endcase
      // header ends at the last byte for the current mode, or past it
      if (byte_pos >= (mode_stereo ? 3'd7 : 3'd3)) begin
        parsing_hdr = 1'b0;
        byte_pos    = '0;
      end else begin
        byte_pos = byte_pos + 3'd1;
      end
    end else begin
      ch = mode_stereo ? byte_pos[2] : 1'b0;
      r = decode_nib(ch, b[3:0], 1'b0);
      if (fixed) r.sample = f_lo;
      pcm_fifo.push_back(r);
      r = decode_nib(ch, b[7:4], 1'b1);
      if (fixed) r.sample = f_hi;
      pcm_fifo.push_back(r);
      byte_pos = byte_pos + 3'd1;
    end
  endfunction

  always @(posedge clk) begin : monitor
    pcm_t got;
    pcm_t want;
    if (!rst_n) begin
      mode_stereo  = 1'b0;
      dec_pred[0]  = '0;
      dec_pred[1]  = '0;
      dec_index[0] = '0;
      dec_index[1] = '0;
      byte_pos     = '0;
      parsing_hdr  = 1'b1;
      pcm_fifo.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.sample = out_tdata;
        got.chan   = out_tuser;
        got.hi_nib = out_tlast;
        if (pcm_fifo.size() == 0) begin
          $display("%0t: unexpected sample %0d ch %0d last %0d", $time,
                   $signed(got.sample), got.chan, got.hi_nib);
          n_errors++;
        end else begin
          want = pcm_fifo.pop_front();
          if (got !== want) begin
            $display("%0t: sample/ch/last expected %0d/%0d/%0d, got %0d/%0d/%0d", $time,
                     $signed(want.sample), want.chan, want.hi_nib,
                     $signed(got.sample), got.chan, got.hi_nib);
            n_errors++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == iabd_pkg::REG_STEREO_MODE) mode_stereo = cfg_pwdata[0];
        end else if (cfg_prdata !== {31'b0, mode_stereo}) begin
          $display("%0t: stereo_mode readback expected %0h, got %0h", $time,
                   {31'b0, mode_stereo}, cfg_prdata);
          n_errors++;
        end
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tuser, fixed_vld, fixed_lo, fixed_hi);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stalls_on && !calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start, input logic fixed,
                           input logic signed [15:0] f_lo, input logic signed [15:0] f_hi);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    fixed_vld <= fixed;
    fixed_lo  <= f_lo;
    fixed_hi  <= f_hi;
    do @(posedge clk); while (!in_tready);
    n_sent++;
    if (n_sent >= CALM_FROM) calm = 1'b1;
  endtask

  task automatic send_raw(input logic [7:0] b, input logic start);
    send_byte(b, start, 1'b0, 16'sh0000, 16'sh0000);
  endtask

  // wait until every pending sample is out, then let the pipeline settle
  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pcm_fifo.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [31:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= iabd_pkg::REG_STEREO_MODE;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic set_mode(input bit stereo);
    apb_xfer(1'b1, {31'b0, stereo});
    apb_xfer(1'b0, 32'b0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_block();
    int         hdr_len;
    int         n_hdr;
    int         n_data;
    logic [7:0] v;
    hdr_len = mode_stereo ? 8 : 4;
    // now and then a header that is cut short
    n_hdr  = ($urandom_range(0, 11) == 0) ? $urandom_range(1, hdr_len - 1) : hdr_len;
    n_data = (n_hdr == hdr_len) ? $urandom_range(1, 24) : 0;
    for (int i = 0; i < n_hdr; i++) begin
      if (i % 4 == 2) begin
        v = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(89, 255)) : 8'($urandom_range(0, 88));
      end else begin
        v = 8'($urandom);
      end
      send_raw(v, i == 0);
    end
    for (int i = 0; i < n_data; i++) send_raw(8'($urandom), 1'b0);
  endtask

  initial begin
    n_errors  = 0;
    n_sent    = 0;
    calm      = 1'b0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    fixed_vld   <= 1'b0;
    fixed_lo    <= '0;
    fixed_hi    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_MODE) begin
        drain(4);
        set_mode(DIRECTED[i].val[0]);
      end else begin
        send_byte(DIRECTED[i].val, DIRECTED[i].start, DIRECTED[i].fixed,
                  DIRECTED[i].f_lo, DIRECTED[i].f_hi);
      end
    end

    while (n_sent < TOTAL_ITEMS) begin
      drain(4);
      set_mode($urandom_range(0, 1));
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray bytes, sometimes flagged as a block start
          repeat ($urandom_range(1, 6)) send_raw(8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
          send_block();
        end
      end
    end

    drain(8);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/iabd_pkg.sv
src/ima_adpcm_block_decoder.sv
tb/tb_ima_adpcm_block_decoder.sv
